FILE: hw/rtl/ldfs_pkg.sv
`default_nettype none
package ldfs_pkg;

    // field index saturates here: past the fourth field
    localparam int unsigned FIELD_COUNT = 4;
    localparam int unsigned FIELD_W     = 3;
    localparam int unsigned OUT_FIELD_W = 2;

    typedef enum logic {
        PH_CAPTURE = 1'b0,
        PH_SCAN    = 1'b1
    } t_phase;

endpackage
`default_nettype wire

FILE: hw/rtl/learned_delimiter_field_splitter.sv
// A result is queued when its byte is accepted, then registered at the output.
// Throughput: one byte per cycle unless the queue is full. A NUL byte gives the
// window bytes plus end marker, one result per cycle while the output is ready.
// A 2-word queue decouples byte intake from result output.
// Reset (synchronous, active low) returns to delimiter capture, empties the queue.
`default_nettype none
module learned_delimiter_field_splitter #(
    parameter int unsigned DELIM_LEN = 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [7:0]                       i_in_byte,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [7:0]                            o_out_byte,
    output logic [ldfs_pkg::OUT_FIELD_W-1:0]      o_out_field,
    output logic                                  o_out_end,
    output logic                                  o_out_last
);
    import ldfs_pkg::*;

    localparam int unsigned CW = $clog2(DELIM_LEN + 1);
    localparam int unsigned QW = DELIM_LEN * 8 + CW + OUT_FIELD_W + 1;

    logic                        push, pop, q_full, q_valid;
    logic [DELIM_LEN-1:0][7:0]   c_bytes, q_bytes;
    logic [CW-1:0]               c_cnt, q_cnt;
    logic [OUT_FIELD_W-1:0]      c_field, q_field;
    logic                        c_end, q_end;
    logic [QW-1:0]               q_in, q_out;

    ldfs_front #(.DELIM_LEN(DELIM_LEN), .CW(CW)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_byte   (i_in_byte),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd_bytes (c_bytes),
        .o_cmd_cnt   (c_cnt),
        .o_cmd_field (c_field),
        .o_cmd_end   (c_end)
    );

    assign q_in = {c_bytes, c_cnt, c_field, c_end};
    assign {q_bytes, q_cnt, q_field, q_end} = q_out;

    ldfs_queue #(.W(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    ldfs_back #(.DELIM_LEN(DELIM_LEN), .CW(CW)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_bytes   (q_bytes),
        .i_q_cnt     (q_cnt),
        .i_q_field   (q_field),
        .i_q_end     (q_end),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_out_field (o_out_field),
        .o_out_end   (o_out_end),
        .o_out_last  (o_out_last)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/ldfs_front.sv
`default_nettype none
module ldfs_front #(
    parameter int unsigned DELIM_LEN = 8,
    parameter int unsigned CW        = 4
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic [7:0]                            i_in_byte,
    input  wire logic                                  i_q_full,
    output logic                                       o_push,
    output logic [DELIM_LEN-1:0][7:0]                  o_cmd_bytes,
    output logic [CW-1:0]                              o_cmd_cnt,
    output logic [ldfs_pkg::OUT_FIELD_W-1:0]           o_cmd_field,
    output logic                                       o_cmd_end
);
    import ldfs_pkg::*;

    t_phase                      r_phase, n_phase;
    logic [CW-1:0]               r_cap, n_cap;
    logic [CW-1:0]               r_fill, n_fill;
    logic [FIELD_W-1:0]          r_field, n_field;
    logic [DELIM_LEN-1:0][7:0]   r_delim, n_delim;
    logic [DELIM_LEN-1:0][7:0]   r_win, n_win;
    logic [DELIM_LEN-1:0][7:0]   cand;
    logic                        accept;
    logic                        in_field;
    logic                        full;
    logic                        match;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign in_field   = (r_field < FIELD_W'(FIELD_COUNT));
    assign full       = (r_fill == CW'(DELIM_LEN - 1));

    // window with the new byte appended at the fill point
    always_comb begin
        for (int i = 0; i < DELIM_LEN; i++) begin
            cand[i] = (r_fill == CW'(i)) ? i_in_byte : r_win[i];
        end
    end

    assign match = (cand == r_delim);

    always_comb begin
        n_phase     = r_phase;
        n_cap       = r_cap;
        n_fill      = r_fill;
        n_field     = r_field;
        n_delim     = r_delim;
        n_win       = r_win;
        o_push      = 1'b0;
        o_cmd_bytes = r_win;
        o_cmd_cnt   = '0;
        o_cmd_field = r_field[OUT_FIELD_W-1:0];
        o_cmd_end   = 1'b0;
        if (accept) begin
            if (i_in_byte == 8'd0) begin
                // flush window, then end marker; restart capture
                o_push    = 1'b1;
                o_cmd_end = 1'b1;
                if (r_phase == PH_SCAN && in_field) begin
                    o_cmd_cnt = r_fill;
                end
                n_phase = PH_CAPTURE;
                n_cap   = '0;
                n_fill  = '0;
                n_field = '0;
            end else if (r_phase == PH_CAPTURE) begin
                for (int i = 0; i < DELIM_LEN; i++) begin
                    if (r_cap == CW'(i)) begin
                        n_delim[i] = i_in_byte;
                    end
                end
                n_cap = r_cap + CW'(1);
                if (r_cap == CW'(DELIM_LEN - 1)) begin
                    n_phase = PH_SCAN;
                end
            end else if (full) begin
                if (match) begin
                    n_fill = '0;
                    if (in_field) begin
                        n_field = r_field + FIELD_W'(1);
                    end
                end else begin
                    if (in_field) begin
                        o_push         = 1'b1;
                        o_cmd_bytes[0] = cand[0];
                        o_cmd_cnt      = CW'(1);
                    end
                    for (int i = 0; i < DELIM_LEN - 1; i++) begin
                        n_win[i] = cand[i+1];
                    end
                end
            end else begin
                n_win  = cand;
                n_fill = r_fill + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CAPTURE;
            r_cap   <= '0;
            r_fill  <= '0;
            r_field <= '0;
        end else begin
            r_phase <= n_phase;
            r_cap   <= n_cap;
            r_fill  <= n_fill;
            r_field <= n_field;
        end
    end

    always_ff @(posedge i_clk) begin
        r_delim <= n_delim;
        r_win   <= n_win;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/ldfs_queue.sv
`default_nettype none
module ldfs_queue #(
    parameter int unsigned W = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic              o_valid,
    output logic [W-1:0]      o_data
);
    import ldfs_pkg::*;

    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/ldfs_back.sv
`default_nettype none
module ldfs_back #(
    parameter int unsigned DELIM_LEN = 8,
    parameter int unsigned CW        = 4
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_q_valid,
    input  wire logic [DELIM_LEN-1:0][7:0]             i_q_bytes,
    input  wire logic [CW-1:0]                         i_q_cnt,
    input  wire logic [ldfs_pkg::OUT_FIELD_W-1:0]      i_q_field,
    input  wire logic                                  i_q_end,
    output logic                                       o_pop,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic [7:0]                                 o_out_byte,
    output logic [ldfs_pkg::OUT_FIELD_W-1:0]           o_out_field,
    output logic                                       o_out_end,
    output logic                                       o_out_last
);
    import ldfs_pkg::*;

    logic                    r_ov;
    logic [CW-1:0]           r_k;
    logic [7:0]              r_byte;
    logic [OUT_FIELD_W-1:0]  r_field;
    logic                    r_end, r_last;
    logic [7:0]              sel;
    logic                    load, take, is_byte, last;
    logic [CW:0]             total;

    always_comb begin
        sel = 8'd0;
        for (int i = 0; i < DELIM_LEN; i++) begin
            if (r_k == CW'(i)) begin
                sel = i_q_bytes[i];
            end
        end
    end

    // results of the head word: cnt bytes, then the end marker if flagged
    assign total   = {1'b0, i_q_cnt} + (CW+1)'(i_q_end);
    assign is_byte = (r_k < i_q_cnt);
    assign last    = ({1'b0, r_k} + (CW+1)'(1) == total);
    assign load    = !r_ov || i_out_ready;
    assign take    = load && i_q_valid;
    assign o_pop   = take && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_k  <= '0;
        end else if (take) begin
            r_ov <= 1'b1;
            r_k  <= last ? '0 : r_k + CW'(1);
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte  <= is_byte ? sel : 8'd0;
            r_field <= is_byte ? i_q_field : '0;
            r_end   <= !is_byte;
            r_last  <= last;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_byte  = r_byte;
    assign o_out_field = r_field;
    assign o_out_end   = r_end;
    assign o_out_last  = r_last;

endmodule
`default_nettype wire
